@@ design/wpa_pkg.sv @@
// Package with the shared widths, codes and types of the windowed pedestal averager.
package wpa_pkg;

  localparam int MAX_TRACE  = 1024;
  localparam int SAMPLE_W   = 12;
  localparam int CNT_W      = $clog2(MAX_TRACE + 1);
  localparam int LEN_W      = 11;
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_TRACE);
  localparam int FRAC_W     = 8;
  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int DIV_W      = CNT_W + LEN_W;
  localparam int PED_W      = 20;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN  = 2'd0,
    REG_PAD_LEN     = 2'd1,
    REG_UNCORR_MODE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] pad_len;
    logic             uncorr;
  } cfg_t;

  // One finished trace, handed from the front end to the back end.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] wcount;
    logic [CNT_W-1:0] scount;
    logic [LEN_W-1:0] wl;
    logic             uncorr;
  } job_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MUL,
    BE_DIV,
    BE_DONE
  } be_state_t;

endpackage

@@ design/wpa_in_if.sv @@
// Sample request channel: valid, ready and one trace sample.
interface wpa_in_if;
  import wpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                is_last;
  modport source (output valid, sample, is_last, input ready);
  modport sink   (input valid, sample, is_last, output ready);
endinterface

@@ design/wpa_out_if.sv @@
// Result request channel: valid, ready and one pedestal result.
interface wpa_out_if;
  import wpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [PED_W-1:0] pedestal_q8;
  logic [LEN_W-1:0] windows_used;
  logic             no_data;
  modport source (output valid, pedestal_q8, windows_used, no_data, input ready);
  modport sink   (input valid, pedestal_q8, windows_used, no_data, output ready);
endinterface

@@ design/wpa_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and write data.
interface wpa_cfg_if;
  import wpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/windowed_pedestal_averager.sv @@
// Top level of the windowed pedestal averager: configuration registers and the three parts.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid / ready        sample[11:0], is_last
//   out_ch   out  valid / ready        pedestal_q8[19:0], windows_used[10:0], no_data
//   cfg_ch   in   valid / ready        index[1:0], data[10:0]
//
// The front end takes one sample request per cycle while the job queue has room.
// A spaced window is finished by the sample that completes it and is committed when a
// later sample of the trace arrives. After the last sample, a result passes through
// the job pop, the divisor multiply, the bit-serial divider (skipped for an empty
// trace) and the output register load; the divider takes the longest.
// The job queue holds two finished traces, so sample requests stall only when
// both entries are full while the back end is still busy with an earlier trace.
// Reset is synchronous and active low; it restores window_len 16, pad_len 0 and
// whole-trace mode, and clears all trace accumulators.
module windowed_pedestal_averager (
  input  logic      clk,
  input  logic      rst_n,
  wpa_in_if.sink    in_ch,
  wpa_out_if.source out_ch,
  wpa_cfg_if.sink   cfg_ch
);
  import wpa_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_acc;
  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // Writes must be made only while the block is idle (unenforced); the port never stalls.
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  // Each register takes the low bits of the write data; an index beyond the
  // register list is accepted and ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_WINDOW_LEN:  cfg_nxt.window_len = cfg_ch.data[LEN_W-1:0];
        REG_PAD_LEN:     cfg_nxt.pad_len    = cfg_ch.data[LEN_W-1:0];
        REG_UNCORR_MODE: cfg_nxt.uncorr     = cfg_ch.data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_len <= LEN_W'(16);
      cfg_r.pad_len    <= '0;
      cfg_r.uncorr     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end sums samples and windows; the last sample of a trace turns
  // its totals into a job for the queue.
  wpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  wpa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  // Back end divides the sum by samples, or windows x length, overlapping the next trace.
  wpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_pop   (pop_ready),
    .job_in    (pop_job),
    .out_ch    (out_ch)
  );

endmodule

@@ design/wpa_front.sv @@
// Front end: accumulates samples, whole-trace or into windows, and emits one job per trace.
module wpa_front (
  input  logic          clk,
  input  logic          rst_n,
  wpa_in_if.sink        in_ch,
  input  wpa_pkg::cfg_t cfg,
  output logic          job_valid,
  input  logic          job_ready,
  output wpa_pkg::job_t job
);
  import wpa_pkg::*;

  logic [SUM_W-1:0] commit_r,   commit_nxt;
  logic [SUM_W-1:0] pend_sum_r, pend_sum_nxt;
  logic             pend_v_r,   pend_v_nxt;
  logic [CNT_W-1:0] wcount_r,   wcount_nxt;
  logic [CNT_W-1:0] scount_r,   scount_nxt;
  logic [LEN_W-1:0] phase_r,    phase_nxt;
  logic             pad_r,      pad_nxt;

  logic             in_acc;
  logic [LEN_W-1:0] wl_eff;
  logic [LEN_W:0]   ph_inc;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid && in_ch.is_last;
  assign wl_eff      = (cfg.window_len == '0) ? LEN_W'(1) : cfg.window_len;
  assign ph_inc      = {1'b0, phase_r} + (LEN_W+1)'(1);

  always_comb begin
    logic [SUM_W-1:0] pend_base;
    commit_nxt   = commit_r;
    pend_sum_nxt = pend_sum_r;
    pend_v_nxt   = pend_v_r;
    wcount_nxt   = wcount_r;
    scount_nxt   = scount_r;
    phase_nxt    = phase_r;
    pad_nxt      = pad_r;
    pend_base    = pend_sum_r;
    if (in_acc && (scount_r < CNT_W'(MAX_TRACE))) begin
      scount_nxt = scount_r + CNT_W'(1);
      if (cfg.uncorr) begin
        // A finished window is committed once a later sample shows up.
        if (pend_v_r) begin
          commit_nxt = commit_r + pend_sum_r;
          wcount_nxt = wcount_r + CNT_W'(1);
          pend_base  = '0;
          pend_v_nxt = 1'b0;
        end
        pend_sum_nxt = pend_base;
        if (pad_r) begin
          if (ph_inc >= {1'b0, cfg.pad_len}) begin
            phase_nxt = '0;
            pad_nxt   = 1'b0;
          end else begin
            phase_nxt = ph_inc[LEN_W-1:0];
          end
        end else begin
          pend_sum_nxt = pend_base + SUM_W'(in_ch.sample);
          if (ph_inc >= {1'b0, wl_eff}) begin
            pend_v_nxt = 1'b1;
            phase_nxt  = '0;
            pad_nxt    = (cfg.pad_len != '0);
          end else begin
            phase_nxt = ph_inc[LEN_W-1:0];
          end
        end
      end else begin
        commit_nxt = commit_r + SUM_W'(in_ch.sample);
      end
    end
    job.sum    = commit_nxt;
    job.wcount = wcount_nxt;
    job.scount = scount_nxt;
    job.wl     = wl_eff;
    job.uncorr = cfg.uncorr;
    if (in_acc && in_ch.is_last) begin
      commit_nxt   = '0;
      pend_sum_nxt = '0;
      pend_v_nxt   = 1'b0;
      wcount_nxt   = '0;
      scount_nxt   = '0;
      phase_nxt    = '0;
      pad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_r   <= '0;
      pend_sum_r <= '0;
      pend_v_r   <= 1'b0;
      wcount_r   <= '0;
      scount_r   <= '0;
      phase_r    <= '0;
      pad_r      <= 1'b0;
    end else begin
      commit_r   <= commit_nxt;
      pend_sum_r <= pend_sum_nxt;
      pend_v_r   <= pend_v_nxt;
      wcount_r   <= wcount_nxt;
      scount_r   <= scount_nxt;
      phase_r    <= phase_nxt;
      pad_r      <= pad_nxt;
    end
  end

  a_trace_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.is_last) |=> (scount_r == '0 && wcount_r == '0 && !pend_v_r))
    else $error("trace state not cleared after the last sample");

endmodule

@@ design/wpa_fifo.sv @@
// Short job queue between the front end and the back end.
module wpa_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  wpa_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output wpa_pkg::job_t pop_data
);
  import wpa_pkg::*;

  job_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r,    cnt_nxt;
  logic                  push, pop;

  assign push_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/wpa_back.sv @@
// Back end: forms the divisor, divides one bit per cycle and holds the result.
module wpa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_pop,
  input  wpa_pkg::job_t job_in,
  wpa_out_if.source     out_ch
);
  import wpa_pkg::*;

  be_state_t            st_r,     st_nxt;
  job_t                 job_r,    job_nxt;
  logic [DIV_W-1:0]     div_r,    div_nxt;
  logic [DIV_W-1:0]     rem_r,    rem_nxt;
  logic [DVD_W-1:0]     dvd_r,    dvd_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,    cnt_nxt;
  logic                 nodata_r, nodata_nxt;
  logic [LEN_W-1:0]     wins_r,   wins_nxt;
  logic                 oval_r,   oval_nxt;
  logic [PED_W-1:0]     oped_r,   oped_nxt;
  logic [LEN_W-1:0]     owins_r,  owins_nxt;
  logic                 ond_r,    ond_nxt;

  logic [DIV_W:0]       rem_sh, rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});

  assign out_ch.valid        = oval_r;
  assign out_ch.pedestal_q8  = oped_r;
  assign out_ch.windows_used = owins_r;
  assign out_ch.no_data      = ond_r;

  always_comb begin
    st_nxt     = st_r;
    job_nxt    = job_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    cnt_nxt    = cnt_r;
    nodata_nxt = nodata_r;
    wins_nxt   = wins_r;
    oval_nxt   = oval_r;
    oped_nxt   = oped_r;
    owins_nxt  = owins_r;
    ond_nxt    = ond_r;
    job_pop    = 1'b0;
    if (oval_r && out_ch.ready) begin
      oval_nxt = 1'b0;
    end
    unique case (st_r)
      BE_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          job_nxt = job_in;
          st_nxt  = BE_MUL;
        end
      end
      BE_MUL: begin
        div_nxt    = job_r.uncorr ? (DIV_W'(job_r.wcount) * DIV_W'(job_r.wl))
                                  : DIV_W'(job_r.scount);
        wins_nxt   = job_r.uncorr ? LEN_W'(job_r.wcount) : LEN_W'(1);
        nodata_nxt = job_r.uncorr ? (job_r.wcount == '0) : (job_r.scount == '0);
        dvd_nxt    = {job_r.sum, FRAC_W'(0)};
        rem_nxt    = '0;
        cnt_nxt    = '0;
        st_nxt     = nodata_nxt ? BE_DONE : BE_DIV;
      end
      BE_DIV: begin
        rem_nxt = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DVD_W-1)) begin
          st_nxt = BE_DONE;
        end
      end
      BE_DONE: begin
        if (!oval_r || out_ch.ready) begin
          oval_nxt  = 1'b1;
          ond_nxt   = nodata_r;
          owins_nxt = nodata_r ? '0 : wins_r;
          if (nodata_r) begin
            oped_nxt = '0;
          end else if (|dvd_r[DVD_W-1:PED_W]) begin
            oped_nxt = '1;
          end else begin
            oped_nxt = dvd_r[PED_W-1:0];
          end
          st_nxt = BE_IDLE;
        end
      end
      default: st_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BE_IDLE;
      oval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    cnt_r    <= cnt_nxt;
    nodata_r <= nodata_nxt;
    wins_r   <= wins_nxt;
    oped_r   <= oped_nxt;
    owins_r  <= owins_nxt;
    ond_r    <= ond_nxt;
  end

  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && ond_r) |-> (oped_r == '0 && owins_r == '0))
    else $error("empty trace result carries a non-zero value");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BE_DIV) |-> (div_r != '0))
    else $error("division started with a zero divisor");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BE_DIV && cnt_r != DIV_CNT_W'(DVD_W-1)) |=> (st_r == BE_DIV))
    else $error("division left before all quotient bits were formed");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the windowed pedestal averager.
`timescale 1ns / 1ps

module testbench;
  import wpa_pkg::*;

  // Cycles allowed for a trace to leave the back end after its last sample
  // plus some margin, used before register writes and at the end.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any accepted request before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int PHASES        = 12;
  localparam int PHASE_SAMPLES = 70;
  localparam longint unsigned PED_CEIL = 1048575;
  localparam longint unsigned WIN_CEIL = 2047;

  // One pedestal result, as the block reports it.
  typedef struct packed {
    logic [PED_W-1:0] pedestal_q8;
    logic [LEN_W-1:0] windows_used;
    logic             no_data;
  } ped_result_t;

  // One row of the directed table: either a register write or a sample.
  // Where typed is set, the expected result is the one written in the row.
  typedef struct {
    bit                  is_write;
    cfg_reg_t            target;
    logic [SAMPLE_W-1:0] value;
    bit                  last;
    bit                  typed;
    ped_result_t         res;
  } stim_row_t;

  localparam int DIR_ROWS = 27;

  logic clk;
  logic rst_n;

  wpa_in_if  in_ch ();
  wpa_out_if out_ch ();
  wpa_cfg_if cfg_ch ();

  windowed_pedestal_averager u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Expected pedestals, oldest first, and the count of failed checks.
  ped_result_t pending_pedestals[$];
  int          mismatches;
  int          stalled_cycles;

  // Idling percentages for the current phase.
  int send_idle_pct;
  int recv_stall_pct;

  // Our own copy of the configuration registers.
  logic [LEN_W-1:0] cfg_wlen;
  logic [LEN_W-1:0] cfg_pad;
  logic             cfg_uncorr;

  // Our own copy of the trace accumulators.
  longint unsigned acc_sum;
  longint unsigned win_sum;
  bit              win_ready;
  int unsigned     win_cnt;
  int unsigned     smp_cnt;
  int unsigned     phase_pos;
  bit              padding;

  // The directed table. It first checks the whole-trace mean at both ends of
  // the sample range, then switches to spaced windows: a zero window length
  // (which behaves as one), a trace whose only window has nothing after it,
  // a window committed by the sample that follows it, full-scale windows,
  // a window and pad pattern, window and pad lengths of 1024, and finally
  // a return to the reset settings.
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{0, REG_WINDOW_LEN,  12'd0,    1, 1, '{20'd0,       11'd1, 1'b0}},
    '{0, REG_WINDOW_LEN,  12'd4095, 1, 1, '{20'd1048320, 11'd1, 1'b0}},
    '{0, REG_WINDOW_LEN,  12'd2048, 0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd5,    1, 0, '0},
    '{1, REG_UNCORR_MODE, 12'd1,    0, 0, '0},
    '{1, REG_WINDOW_LEN,  12'd0,    0, 0, '0},
    '{1, REG_PAD_LEN,     12'd0,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd7,    1, 1, '{20'd0,       11'd0, 1'b1}},
    '{0, REG_WINDOW_LEN,  12'd10,   0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd20,   1, 1, '{20'd2560,    11'd1, 1'b0}},
    '{0, REG_WINDOW_LEN,  12'd4095, 0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd4095, 1, 1, '{20'd1048320, 11'd1, 1'b0}},
    '{1, REG_WINDOW_LEN,  12'd2,    0, 0, '0},
    '{1, REG_PAD_LEN,     12'd1,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd1,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd2,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd3,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd4,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd5,    1, 0, '0},
    '{1, REG_WINDOW_LEN,  12'd1024, 0, 0, '0},
    '{1, REG_PAD_LEN,     12'd1024, 0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd100,  1, 1, '{20'd0,       11'd0, 1'b1}},
    '{1, REG_UNCORR_MODE, 12'd0,    0, 0, '0},
    '{1, REG_WINDOW_LEN,  12'd16,   0, 0, '0},
    '{1, REG_PAD_LEN,     12'd0,    0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd4095, 0, 0, '0},
    '{0, REG_WINDOW_LEN,  12'd0,    1, 1, '{20'd524160,  11'd1, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Forget the trace in progress, as the block does after every last sample.
  function automatic void clear_trace_state();
    acc_sum   = 0;
    win_sum   = 0;
    win_ready = 0;
    win_cnt   = 0;
    smp_cnt   = 0;
    phase_pos = 0;
    padding   = 0;
  endfunction

  // Advance the prediction by one accepted sample. Returns 1, with the
  // expected pedestal in res, when the sample closes its trace.
  function automatic bit predict_pedestal(input logic [SAMPLE_W-1:0] s, input bit last,
                                          output ped_result_t res);
    int unsigned     wl;
    longint unsigned divisor;
    longint unsigned quotient;
    longint unsigned wins;
    wl  = (cfg_wlen == 0) ? 1 : cfg_wlen;
    res = '0;
    // Samples beyond the longest trace are dropped, but is_last still counts.
    if (smp_cnt < MAX_TRACE) begin
      smp_cnt++;
      if (cfg_uncorr) begin
        // A finished window is only committed once another sample turns up.
        if (win_ready) begin
          acc_sum  += win_sum;
          win_cnt++;
          win_sum   = 0;
          win_ready = 0;
        end
        phase_pos++;
        if (padding) begin
          if (phase_pos >= cfg_pad) begin
            phase_pos = 0;
            padding   = 0;
          end
        end else begin
          win_sum += s;
          if (phase_pos >= wl) begin
            win_ready = 1;
            phase_pos = 0;
            padding   = (cfg_pad != 0);
          end
        end
      end else begin
        acc_sum += s;
      end
    end
    if (!last) return 0;

    if (cfg_uncorr) begin
      wins    = win_cnt;
      divisor = longint'(win_cnt) * wl;
    end else begin
      wins    = 1;
      divisor = smp_cnt;
    end
    if (divisor == 0) begin
      res.no_data = 1'b1;
    end else begin
      quotient         = (acc_sum << 8) / divisor;
      res.pedestal_q8  = (quotient > PED_CEIL) ? PED_CEIL[PED_W-1:0] : quotient[PED_W-1:0];
      res.windows_used = (wins > WIN_CEIL) ? WIN_CEIL[LEN_W-1:0] : wins[LEN_W-1:0];
    end
    clear_trace_state();
    return 1;
  endfunction

  // Trace length for the random part. Spaced-window traces are sized to run
  // through a few window and pad periods, so that windows actually close.
  function automatic int pick_trace_len();
    int unsigned period;
    int unsigned ceiling;
    period = ((cfg_wlen == 0) ? 1 : cfg_wlen) + cfg_pad;
    if ($urandom_range(0, 99) < 5) return 1;
    if (cfg_uncorr && period <= 120) begin
      ceiling = 4 * period + 2;
      return $urandom_range(1, (ceiling > 120) ? 120 : ceiling);
    end
    if (cfg_uncorr) return $urandom_range(1, 120);
    return $urandom_range(1, 40);
  endfunction

  // Samples lean towards both ends of the ADC range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  // Offer one sample request, after any idle cycles, and predict its effect
  // once it has been accepted. Valid stays high afterwards so that the next
  // request can follow back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit last,
                             input bit use_typed, input ped_result_t typed_res);
    ped_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_pedestal(s, last, predicted))
      pending_pedestals.insert(pending_pedestals.size(), use_typed ? typed_res : predicted);
  endtask

  // Offer one register write request. The caller lowers valid after the last
  // write of a group, so that valid is never dropped and raised in one step.
  task automatic write_reg(input cfg_reg_t target, input logic [LEN_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= target;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (target)
      REG_WINDOW_LEN:  cfg_wlen   = value;
      REG_PAD_LEN:     cfg_pad    = value;
      REG_UNCORR_MODE: cfg_uncorr = value[0];
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected pedestal has come back, then
  // give the back end time to finish anything still in flight.
  task automatic wait_until_quiet();
    in_ch.valid <= 1'b0;
    while (pending_pedestals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input bit mode, input logic [LEN_W-1:0] wl,
                               input logic [LEN_W-1:0] pad);
    wait_until_quiet();
    write_reg(REG_UNCORR_MODE, {{(LEN_W-1){1'b0}}, mode});
    write_reg(REG_WINDOW_LEN, wl);
    write_reg(REG_PAD_LEN, pad);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random back-pressure, and every accepted result is checked
  // against the oldest expected pedestal.
  always @(posedge clk) begin : check_results
    ped_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pedestals.size() == 0) begin
        $error("unexpected result: pedestal_q8 %0d windows_used %0d no_data %0d",
               out_ch.pedestal_q8, out_ch.windows_used, out_ch.no_data);
        mismatches++;
      end else begin
        want = pending_pedestals.pop_front();
        if (out_ch.pedestal_q8 !== want.pedestal_q8) begin
          $error("pedestal_q8: expected %0d, actual %0d", want.pedestal_q8,
                 out_ch.pedestal_q8);
          mismatches++;
        end
        if (out_ch.windows_used !== want.windows_used) begin
          $error("windows_used: expected %0d, actual %0d", want.windows_used,
                 out_ch.windows_used);
          mismatches++;
        end
        if (out_ch.no_data !== want.no_data) begin
          $error("no_data: expected %0d, actual %0d", want.no_data, out_ch.no_data);
          mismatches++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= HANG_LIMIT) begin
          $display("** windowed_pedestal_averager: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int          ph;
    int          budget;
    int          len;
    bit          mode;
    logic [LEN_W-1:0] wl;
    logic [LEN_W-1:0] pad;

    // Every input is known from time zero.
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    in_ch.is_last  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_WINDOW_LEN;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    stalled_cycles = 0;
    cfg_wlen       = 16;
    cfg_pad        = 0;
    cfg_uncorr     = 1'b0;
    clear_trace_state();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with no idling on either side. A run of register writes
    // only starts once the block has gone quiet.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].is_write) begin
        if (i == 0 || !directed_rows[i-1].is_write) wait_until_quiet();
        write_reg(directed_rows[i].target, directed_rows[i].value[LEN_W-1:0]);
        if (i == DIR_ROWS - 1 || !directed_rows[i+1].is_write) cfg_ch.valid <= 1'b0;
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // Random part. Each phase starts from a quiet block with a fresh setting,
    // which also makes the sender pause until every result is back. The idling
    // pattern cycles through none, sender gaps, receiver stalls and both.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin mode = 0; wl = 16;   pad = 0;    end
        1: begin mode = 1; wl = 4;    pad = 2;    end
        2: begin mode = 1; wl = 1;    pad = 0;    end
        3: begin mode = 1; wl = 2047; pad = 2047; end
        4: begin mode = 1; wl = 3;    pad = 1024; end
        default: begin
          mode = 1'($urandom_range(0, 1));
          wl   = ($urandom_range(0, 9) == 0) ? '0 : LEN_W'($urandom_range(1, 12));
          pad  = LEN_W'($urandom_range(0, 6));
        end
      endcase
      apply_setting(mode, wl, pad);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase

      // The last trace of a phase is cut short so that each phase carries
      // exactly its share of samples.
      budget = PHASE_SAMPLES;
      while (budget > 0) begin
        len = pick_trace_len();
        if (len > budget) len = budget;
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1, 0, '0);
        budget -= len;
      end
    end

    wait_until_quiet();
    if (mismatches == 0) begin
      $display("** windowed_pedestal_averager: PASSED **");
    end else begin
      $display("** windowed_pedestal_averager: FAILED **");
    end
    $finish;
  end

endmodule
